/* hdl/resp_request_parser_assert.svh */
// Assertion macros shared by the request parser RTL.
`ifndef RESP_REQUEST_PARSER_ASSERT_SVH
`define RESP_REQUEST_PARSER_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off while in reset.
`define RRP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("parser check failed");

// Next-cycle implication, clocked on aclk, off while in reset.
`define RRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("parser check failed");

`endif

/* hdl/rrp_pkg.sv */
// Shared types and result codes for the request parser.
`default_nettype none

package rrp_pkg;

    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_ARG_END = 2'd1;
    localparam logic [1:0] KIND_CMD_END = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] ERR_NUMBER = 2'd0;
    localparam logic [1:0] ERR_DOLLAR = 2'd1;
    localparam logic [1:0] ERR_LIMIT  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] arg_count;
        logic [1:0]  err_code;
    } result_t;

    // One or two results produced by a single request byte.
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

endpackage

`default_nettype wire

/* hdl/rrp_front.sv */
// Front end: takes request bytes, tracks parse state, builds result entries.
`default_nettype none

module rrp_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [30:0]       cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_byte_req,
    input  wire logic              q_full,
    output logic                   q_push,
    output rrp_pkg::entry_t        q_entry
);

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_COUNT   = 4'd1;
    localparam logic [3:0] M_DOLLAR  = 4'd2;
    localparam logic [3:0] M_LEN     = 4'd3;
    localparam logic [3:0] M_DATA    = 4'd4;
    localparam logic [3:0] M_SKIP1   = 4'd5;
    localparam logic [3:0] M_SKIP2   = 4'd6;
    localparam logic [3:0] M_INLINE  = 4'd7;
    localparam logic [3:0] M_DISCARD = 4'd8;

    localparam logic [1:0] PH_PRE  = 2'd0;
    localparam logic [1:0] PH_SIGN = 2'd1;
    localparam logic [1:0] PH_DIG  = 2'd2;
    localparam logic [1:0] PH_END  = 2'd3;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;

    localparam logic [15:0] MAX_ARG_RESET  = 16'd1024;
    localparam logic [30:0] MAX_BULK_RESET = 31'd536870912;

    typedef struct packed {
        logic [31:0] accum;
        logic        neg;
        logic [1:0]  phase;
        logic        bad;
    } num_t;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == 8'h20) || (c == 8'h09) || (c == CH_LF) || (c == 8'h0B) ||
                (c == 8'h0C) || (c == CH_CR);
    endfunction

    function automatic rrp_pkg::result_t mk(input logic [1:0] kind, input logic [7:0] data,
                                            input logic [15:0] cnt, input logic [1:0] err);
        rrp_pkg::result_t r;
        r.kind      = kind;
        r.data      = data;
        r.arg_count = cnt;
        r.err_code  = err;
        mk = r;
    endfunction

    function automatic num_t feed(input num_t st, input logic [7:0] c);
        num_t        r;
        logic        dig;
        logic [35:0] prod;
        r     = st;
        r.bad = 1'b0;
        dig   = (c >= CH_0) && (c <= CH_9);
        prod  = ({4'b0, st.accum} << 3) + ({4'b0, st.accum} << 1) + {32'b0, c[3:0]};
        case (st.phase)
            PH_PRE: begin
                if (is_ws(c)) begin
                    r.phase = PH_PRE;
                end else if (c == CH_PLUS) begin
                    r.phase = PH_SIGN;
                end else if (c == CH_MINUS) begin
                    r.neg   = 1'b1;
                    r.phase = PH_SIGN;
                end else if (!dig) begin
                    r.bad = 1'b1;
                end else begin
                    r.accum = {28'b0, c[3:0]};
                    r.phase = PH_DIG;
                end
            end
            PH_SIGN: begin
                if (!dig) begin
                    r.bad = 1'b1;
                end else begin
                    r.accum = {28'b0, c[3:0]};
                    r.phase = PH_DIG;
                end
            end
            PH_DIG: begin
                if (!dig) begin
                    r.phase = PH_END;
                end else if (prod[35:32] != 4'd0) begin
                    r.accum = 32'hFFFF_FFFF;
                end else begin
                    r.accum = prod[31:0];
                end
            end
            default: begin
                r.phase = st.phase;
            end
        endcase
        feed = r;
    endfunction

    logic [3:0]  mode_reg, mode_next;
    logic [31:0] accum_reg, accum_next;
    logic        neg_reg, neg_next;
    logic [1:0]  phase_reg, phase_next;
    logic        saw_cr_reg, saw_cr_next;
    logic [15:0] elements_reg, elements_next;
    logic [30:0] bytes_reg, bytes_next;
    logic        tok_reg, tok_next;
    logic [15:0] args_reg, args_next;
    logic [15:0] max_arg_reg;
    logic [30:0] max_bulk_reg;

    logic             accept;
    logic [7:0]       b;
    logic             two;
    logic             any;
    rrp_pkg::result_t res0, res1;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_byte_req;

    always_comb begin
        logic        tok_cur;
        logic [15:0] args_cur;
        logic [15:0] args_inc;
        logic [15:0] el_dec;
        logic        do_inline;
        logic        num_bad;
        logic        zero_or_neg;
        logic [3:0]  fail_mode;
        num_t        st_a;
        num_t        st_b;

        mode_next     = mode_reg;
        accum_next    = accum_reg;
        neg_next      = neg_reg;
        phase_next    = phase_reg;
        saw_cr_next   = saw_cr_reg;
        elements_next = elements_reg;
        bytes_next    = bytes_reg;
        tok_next      = tok_reg;
        args_next     = args_reg;
        tok_cur       = tok_reg;
        args_cur      = args_reg;
        args_inc      = (args_reg != 16'hFFFF) ? args_reg + 16'd1 : args_reg;
        el_dec        = (elements_reg != 16'd0) ? elements_reg - 16'd1 : elements_reg;
        do_inline     = 1'b0;
        any           = 1'b0;
        two           = 1'b0;
        res0          = '0;
        res1          = '0;
        fail_mode     = (b == CH_LF) ? M_IDLE : M_DISCARD;
        st_a.accum    = accum_reg;
        st_a.neg      = neg_reg;
        st_a.phase    = phase_reg;
        st_a.bad      = 1'b0;
        st_b          = st_a;
        num_bad       = (phase_reg == PH_PRE) || (phase_reg == PH_SIGN) ||
                        (!neg_reg && (accum_reg > 32'h7FFF_FFFF)) ||
                        (neg_reg && (accum_reg > 32'h8000_0000));
        zero_or_neg   = neg_reg || (accum_reg == 32'd0);

        case (mode_reg)
            M_IDLE: begin
                args_next = 16'd0;
                tok_next  = 1'b0;
                tok_cur   = 1'b0;
                args_cur  = 16'd0;
                if (b == CH_STAR) begin
                    accum_next  = 32'd0;
                    neg_next    = 1'b0;
                    phase_next  = PH_PRE;
                    saw_cr_next = 1'b0;
                    mode_next   = M_COUNT;
                end else begin
                    mode_next = M_INLINE;
                    do_inline = 1'b1;
                end
            end
            M_COUNT, M_LEN: begin
                saw_cr_next = 1'b0;
                if (saw_cr_reg && (b == CH_LF)) begin
                    any = 1'b1;
                    if (num_bad) begin
                        res0      = mk(rrp_pkg::KIND_ERROR, 8'd0, 16'd0, rrp_pkg::ERR_NUMBER);
                        mode_next = M_IDLE;
                    end else if (mode_reg == M_COUNT) begin
                        if (zero_or_neg) begin
                            res0      = mk(rrp_pkg::KIND_CMD_END, 8'd0, 16'd0, 2'd0);
                            mode_next = M_IDLE;
                        end else if (accum_reg > {16'b0, max_arg_reg}) begin
                            res0      = mk(rrp_pkg::KIND_ERROR, 8'd0, 16'd0, rrp_pkg::ERR_LIMIT);
                            mode_next = M_IDLE;
                        end else begin
                            any           = 1'b0;
                            elements_next = accum_reg[15:0];
                            mode_next     = M_DOLLAR;
                        end
                    end else begin
                        if ((neg_reg && (accum_reg != 32'd0)) ||
                            (accum_reg > {1'b0, max_bulk_reg})) begin
                            res0      = mk(rrp_pkg::KIND_ERROR, 8'd0, 16'd0, rrp_pkg::ERR_LIMIT);
                            mode_next = M_IDLE;
                        end else begin
                            any        = 1'b0;
                            bytes_next = neg_reg ? 31'd0 : accum_reg[30:0];
                            mode_next  = zero_or_neg ? M_SKIP1 : M_DATA;
                        end
                    end
                end else begin
                    if (saw_cr_reg) begin
                        st_a = feed(st_a, CH_CR);
                    end
                    if (st_a.bad) begin
                        any       = 1'b1;
                        res0      = mk(rrp_pkg::KIND_ERROR, 8'd0, 16'd0, rrp_pkg::ERR_NUMBER);
                        mode_next = fail_mode;
                    end else if (b == CH_CR) begin
                        saw_cr_next = 1'b1;
                        accum_next  = st_a.accum;
                        neg_next    = st_a.neg;
                        phase_next  = st_a.phase;
                    end else begin
                        st_b       = feed(st_a, b);
                        accum_next = st_b.accum;
                        neg_next   = st_b.neg;
                        phase_next = st_b.phase;
                        if (st_b.bad) begin
                            any       = 1'b1;
                            res0      = mk(rrp_pkg::KIND_ERROR, 8'd0, 16'd0,
                                           rrp_pkg::ERR_NUMBER);
                            mode_next = fail_mode;
                        end
                    end
                end
            end
            M_DOLLAR: begin
                if (b == CH_DOLLAR) begin
                    accum_next  = 32'd0;
                    neg_next    = 1'b0;
                    phase_next  = PH_PRE;
                    saw_cr_next = 1'b0;
                    mode_next   = M_LEN;
                end else begin
                    any       = 1'b1;
                    res0      = mk(rrp_pkg::KIND_ERROR, 8'd0, 16'd0, rrp_pkg::ERR_DOLLAR);
                    mode_next = fail_mode;
                end
            end
            M_DATA: begin
                any        = 1'b1;
                res0       = mk(rrp_pkg::KIND_BYTE, b, 16'd0, 2'd0);
                bytes_next = bytes_reg - 31'd1;
                if (bytes_reg == 31'd1) begin
                    mode_next = M_SKIP1;
                end
            end
            M_SKIP1: begin
                mode_next = M_SKIP2;
            end
            M_SKIP2: begin
                any           = 1'b1;
                args_next     = args_inc;
                elements_next = el_dec;
                res0          = mk(rrp_pkg::KIND_ARG_END, 8'd0, 16'd0, 2'd0);
                if (el_dec == 16'd0) begin
                    two       = 1'b1;
                    res1      = mk(rrp_pkg::KIND_CMD_END, 8'd0, args_inc, 2'd0);
                    mode_next = M_IDLE;
                end else begin
                    mode_next = M_DOLLAR;
                end
            end
            M_INLINE: begin
                do_inline = 1'b1;
            end
            default: begin
                mode_next = (b == CH_LF) ? M_IDLE : M_DISCARD;
            end
        endcase

        if (do_inline) begin
            if (!is_ws(b)) begin
                any      = 1'b1;
                res0     = mk(rrp_pkg::KIND_BYTE, b, 16'd0, 2'd0);
                tok_next = 1'b1;
            end else begin
                tok_next = 1'b0;
                if (tok_cur) begin
                    any       = 1'b1;
                    args_next = args_inc;
                    res0      = mk(rrp_pkg::KIND_ARG_END, 8'd0, 16'd0, 2'd0);
                    if (b == CH_LF) begin
                        two       = 1'b1;
                        res1      = mk(rrp_pkg::KIND_CMD_END, 8'd0, args_inc, 2'd0);
                        mode_next = M_IDLE;
                    end
                end else if (b == CH_LF) begin
                    any       = 1'b1;
                    res0      = mk(rrp_pkg::KIND_CMD_END, 8'd0, args_cur, 2'd0);
                    mode_next = M_IDLE;
                end
            end
        end
    end

    assign q_push     = accept && any;
    assign q_entry.two = two;
    assign q_entry.r0  = res0;
    assign q_entry.r1  = res1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_arg_reg  <= MAX_ARG_RESET;
            max_bulk_reg <= MAX_BULK_RESET;
        end else if (cfg_we) begin
            if (cfg_index) begin
                max_bulk_reg <= cfg_wdata;
            end else begin
                max_arg_reg <= cfg_wdata[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= M_IDLE;
            accum_reg    <= 32'd0;
            neg_reg      <= 1'b0;
            phase_reg    <= PH_PRE;
            saw_cr_reg   <= 1'b0;
            elements_reg <= 16'd0;
            bytes_reg    <= 31'd0;
            tok_reg      <= 1'b0;
            args_reg     <= 16'd0;
        end else if (accept) begin
            mode_reg     <= mode_next;
            accum_reg    <= accum_next;
            neg_reg      <= neg_next;
            phase_reg    <= phase_next;
            saw_cr_reg   <= saw_cr_next;
            elements_reg <= elements_next;
            bytes_reg    <= bytes_next;
            tok_reg      <= tok_next;
            args_reg     <= args_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/rrp_queue.sv */
// Small FIFO of result entries between the front end and the output stage.
`default_nettype none

module rrp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire rrp_pkg::entry_t push_entry,
    input  wire logic            pop,
    output rrp_pkg::entry_t      head,
    output logic                 not_empty,
    output logic                 full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    rrp_pkg::entry_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_FULL);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/rrp_emit.sv */
// Output stage: holds one entry and hands out its results one beat at a time.
`default_nettype none

module rrp_emit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_not_empty,
    input  wire rrp_pkg::entry_t q_head,
    output logic                 q_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [1:0]           m_kind,
    output logic [7:0]           m_data,
    output logic [15:0]          m_arg_count,
    output logic [1:0]           m_err_code,
    output logic                 m_last
);

    logic             valid_reg;
    logic             sel_reg;
    rrp_pkg::entry_t  hold_reg;
    rrp_pkg::result_t cur;
    logic             beat;
    logic             finish;

    assign cur    = sel_reg ? hold_reg.r1 : hold_reg.r0;
    assign beat   = valid_reg && m_ready;
    assign finish = beat && (!hold_reg.two || sel_reg);
    assign q_pop  = q_not_empty && (!valid_reg || finish);

    assign m_valid     = valid_reg;
    assign m_kind      = cur.kind;
    assign m_data      = cur.data;
    assign m_arg_count = cur.arg_count;
    assign m_err_code  = cur.err_code;
    assign m_last      = !hold_reg.two || sel_reg;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            hold_reg <= q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
            sel_reg   <= 1'b0;
        end else if (finish) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else if (beat) begin
            sel_reg <= 1'b1;
        end
    end

endmodule

`default_nettype wire

/* hdl/resp_request_parser.sv */
// Request parser top level: front end, entry FIFO and output stage.
// With the output idle, a byte's entry passes through the FIFO and the output hold register.
// Throughput: one byte per cycle; while m_ready is high the output moves one result per cycle,
// so two-result bytes queue in the QUEUE_DEPTH-entry FIFO and s_ready drops while it is full.
// Reset (aresetn low, synchronous): limits return to 1024 and 2^29, parser idle,
// FIFO and output empty.
`default_nettype none

`include "resp_request_parser_assert.svh"

module resp_request_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [30:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_byte_req,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_kind,
    output logic [7:0]       m_data,
    output logic [15:0]      m_arg_count,
    output logic [1:0]       m_err_code,
    output logic             m_last
);

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_not_empty;
    rrp_pkg::entry_t q_in;
    rrp_pkg::entry_t q_head;

    rrp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_byte_req (s_byte_req),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (q_in)
    );

    rrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .not_empty  (q_not_empty),
        .full       (q_full)
    );

    rrp_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_data      (m_data),
        .m_arg_count (m_arg_count),
        .m_err_code  (m_err_code),
        .m_last      (m_last)
    );

    `RRP_ASSERT_NOW(a_no_push_full, q_push, !q_full)
    `RRP_ASSERT_NOW(a_data_only_bytes, m_valid && (m_kind != rrp_pkg::KIND_BYTE), m_data == 8'd0)
    `RRP_ASSERT_NOW(a_error_last, m_valid && (m_kind == rrp_pkg::KIND_ERROR), m_last)
    `RRP_ASSERT_NEXT(a_pop_fills_out, q_pop, m_valid)

endmodule

`default_nettype wire
